// File: hw/rtl/bbdr_pkg.sv
// ----------------------------------------------------------------------------
// bbdr_pkg: shared constants for the beam-break debounce / rearm block
// Channel count, field widths, stream packing, command and register codes.
// ----------------------------------------------------------------------------
package bbdr_pkg;

  localparam int CHANNELS = 6;
  localparam int CH_W     = $clog2(CHANNELS);

  // field widths
  localparam int MODE_W   = 2;
  localparam int MASK_W   = 6;
  localparam int TIME_W   = 32;
  localparam int CHAN_W   = 3;
  localparam int DEB_W    = 16;

  // stream packing (whole bytes)
  localparam int IN_TDATA_W  = 48;  // raw_levels, now_ms, channel
  localparam int IN_TUSER_W  = MODE_W;
  localparam int OUT_TDATA_W = 24;  // fired, stable, armed, pending
  localparam int IN_USED_W   = MASK_W + TIME_W + CHAN_W;
  localparam int OUT_USED_W  = 1 + 3 * MASK_W;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_DEBOUNCE = 2'd0;
  localparam cfg_idx_t REG_REARM    = 2'd1;
  localparam cfg_idx_t REG_INVERT   = 2'd2;
  localparam cfg_idx_t REG_USED     = 2'd3;

  // reset values
  localparam logic [DEB_W-1:0]  DEBOUNCE_RST = 16'd30;
  localparam logic [TIME_W-1:0] REARM_RST    = 32'd20000;

  // commands carried in tuser
  typedef logic [MODE_W-1:0] mode_t;
  localparam mode_t MODE_SAMPLE  = 2'd0;
  localparam mode_t MODE_READ    = 2'd1;
  localparam mode_t MODE_RESTORE = 2'd2;

endpackage

// File: hw/rtl/beam_break_debounce_rearm.sv
// ----------------------------------------------------------------------------
// beam_break_debounce_rearm: six-channel beam debounce with one-shot rearm
// Debounces beam inputs, latches one-shot break events, re-arms after holdoff.
// ----------------------------------------------------------------------------
// Usage
//   in_*  : command stream. tuser = mode (0 sample, 1 read and clear event,
//           2 re-establish channel, 3 no-op). tdata = raw_levels, now_ms and
//           channel. One result per command on out_*.
//   out_* : status stream: fired flag plus stable, armed and pending masks.
//   cfg_* : register writes (debounce_limit, rearm_limit, invert_mask,
//           used_mask), taken any cycle cfg_we is high; write only while idle.
// Sequencing
//   A sample walks the channels with one shared 32-bit subtract/compare unit:
//   each used channel passes the debounce check, the rearm reference select
//   and the rearm check, each unused channel the debounce check alone; then
//   the result is loaded. Read / re-establish / no-op: the command step,
//   then the result load. in_tready is high only in idle, so the next command
//   is taken the cycle after the result is loaded.
// Reset (rst_n low, synchronous): registers to their defaults, all channels
//   armed, other channel state and the fired flag cleared; no result pending.
// Stall: the result sits in the output register; a new command may still be
//   accepted and processed, and its result waits until the old one leaves.
// ----------------------------------------------------------------------------
module beam_break_debounce_rearm (
  input  logic                                clk,
  input  logic                                rst_n,
  // command stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [bbdr_pkg::IN_TDATA_W-1:0]     in_tdata,   // raw_levels, now_ms, channel
  input  logic [bbdr_pkg::IN_TUSER_W-1:0]     in_tuser,   // mode
  // status stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [bbdr_pkg::OUT_TDATA_W-1:0]    out_tdata,  // fired, stable, armed, pending
  // register writes
  input  logic                                cfg_we,
  input  logic [bbdr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bbdr_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int NCH  = bbdr_pkg::CHANNELS;
  localparam int CHW  = bbdr_pkg::CH_W;
  localparam int TW   = bbdr_pkg::TIME_W;
  localparam int MW   = bbdr_pkg::MASK_W;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_DEB   = 6'b000010,  // raw change + debounce compare
    S_MAX   = 6'b000100,  // rearm reference = later of fire/change time
    S_REARM = 6'b001000,  // rearm holdoff compare
    S_CMD   = 6'b010000,  // read-clear or re-establish one channel
    S_DONE  = 6'b100000   // load output register
  } state_t;

  state_t st_r, st_nxt;

  // configuration
  logic [bbdr_pkg::DEB_W-1:0] debounce_r;
  logic [TW-1:0]              rearm_r;
  logic [MW-1:0]              invert_r;
  logic [MW-1:0]              used_r;

  // captured command
  bbdr_pkg::mode_t            mode_r;
  logic [MW-1:0]              raw_r;
  logic [TW-1:0]              now_r;
  logic [bbdr_pkg::CHAN_W-1:0] chan_r;

  // per-channel state
  logic                       raw_seen_r  [NCH];
  logic                       stable_r    [NCH];
  logic                       event_r     [NCH];
  logic                       armed_r     [NCH];
  logic [TW-1:0]              chg_time_r  [NCH];
  logic [TW-1:0]              fire_time_r [NCH];

  logic [CHW-1:0]             ch_r;
  logic [TW-1:0]              ref_r;
  logic                       fired_r;

  // output register
  logic                       out_valid_r;
  logic [bbdr_pkg::OUT_TDATA_W-1:0] out_data_r;

  // ---------------------------------------------------------------------------
  // Shared subtract / compare unit
  // ---------------------------------------------------------------------------
  logic [TW-1:0] unit_a, unit_b, unit_lim;
  logic [TW:0]   unit_diff;
  logic          unit_borrow, unit_ge;

  logic          cur_raw, raw_chg, cur_broken, ch_used;

  assign ch_used    = used_r[ch_r];
  assign cur_raw    = raw_r[ch_r];
  assign raw_chg    = cur_raw != raw_seen_r[ch_r];
  assign cur_broken = invert_r[ch_r] ? cur_raw : ~cur_raw;

  always_comb begin
    unit_a   = now_r;
    unit_b   = chg_time_r[ch_r];
    unit_lim = {{(TW - bbdr_pkg::DEB_W){1'b0}}, debounce_r};
    case (st_r)
      S_DEB: begin
        unit_b = raw_chg ? now_r : chg_time_r[ch_r];
      end
      S_MAX: begin
        unit_a = chg_time_r[ch_r];
        unit_b = fire_time_r[ch_r];
      end
      S_REARM: begin
        unit_b   = ref_r;
        unit_lim = rearm_r;
      end
      default: ;
    endcase
  end

  assign unit_diff   = {1'b0, unit_a} - {1'b0, unit_b};
  assign unit_borrow = unit_diff[TW];          // a < b
  assign unit_ge     = unit_diff[TW-1:0] >= unit_lim;

  // ---------------------------------------------------------------------------
  // Command decode for modes 1 and 2
  // ---------------------------------------------------------------------------
  logic [CHW-1:0] cmd_idx;
  logic           cmd_ok;
  logic           cmd_raw;

  assign cmd_idx = CHW'(chan_r);
  assign cmd_ok  = (32'(chan_r) < NCH) && used_r[cmd_idx];
  assign cmd_raw = raw_r[cmd_idx];

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  logic last_ch;
  logic in_xfer;
  logic out_load;

  assign last_ch  = ch_r == CHW'(NCH - 1);
  assign in_tready = st_r == S_IDLE;
  assign in_xfer  = in_tvalid && in_tready;
  assign out_load = (st_r == S_DONE) && (!out_valid_r || out_tready);

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE: begin
        if (in_tvalid) begin
          st_nxt = (in_tuser == bbdr_pkg::MODE_SAMPLE) ? S_DEB : S_CMD;
        end
      end
      S_DEB: begin
        if (ch_used) st_nxt = S_MAX;
        else if (last_ch) st_nxt = S_DONE;
      end
      S_MAX:   st_nxt = S_REARM;
      S_REARM: st_nxt = last_ch ? S_DONE : S_DEB;
      S_CMD:   st_nxt = S_DONE;
      S_DONE: begin
        if (out_load) st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      ch_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (in_xfer) begin
        ch_r <= '0;
      end else if ((st_r == S_DEB && !ch_used && !last_ch) ||
                   (st_r == S_REARM && !last_ch)) begin
        ch_r <= ch_r + 1'b1;
      end
    end
  end

  // command capture
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      mode_r <= in_tuser;
      raw_r  <= in_tdata[MW-1:0];
      now_r  <= in_tdata[MW +: TW];
      chan_r <= in_tdata[MW + TW +: bbdr_pkg::CHAN_W];
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= bbdr_pkg::DEBOUNCE_RST;
      rearm_r    <= bbdr_pkg::REARM_RST;
      invert_r   <= '0;
      used_r     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        bbdr_pkg::REG_DEBOUNCE: debounce_r <= cfg_wdata[bbdr_pkg::DEB_W-1:0];
        bbdr_pkg::REG_REARM:    rearm_r    <= cfg_wdata[TW-1:0];
        bbdr_pkg::REG_INVERT:   invert_r   <= cfg_wdata[MW-1:0];
        bbdr_pkg::REG_USED:     used_r     <= cfg_wdata[MW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Channel state updates
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NCH; i++) begin
        raw_seen_r[i]  <= 1'b0;
        stable_r[i]    <= 1'b0;
        event_r[i]     <= 1'b0;
        armed_r[i]     <= 1'b1;
        chg_time_r[i]  <= '0;
        fire_time_r[i] <= '0;
      end
      fired_r <= 1'b0;
    end else begin
      case (st_r)
        S_IDLE: begin
          if (in_xfer) fired_r <= 1'b0;
        end
        S_DEB: begin
          if (ch_used) begin
            if (raw_chg) begin
              raw_seen_r[ch_r] <= cur_raw;
              chg_time_r[ch_r] <= now_r;
            end
            // stable edge; into broken fires once if armed
            if (unit_ge && (cur_broken != stable_r[ch_r])) begin
              stable_r[ch_r] <= cur_broken;
              if (cur_broken && armed_r[ch_r]) begin
                event_r[ch_r]     <= 1'b1;
                armed_r[ch_r]     <= 1'b0;
                fire_time_r[ch_r] <= now_r;
              end
            end
          end
        end
        S_REARM: begin
          if (!armed_r[ch_r] && !stable_r[ch_r] && unit_ge) armed_r[ch_r] <= 1'b1;
        end
        S_CMD: begin
          if (cmd_ok) begin
            if (mode_r == bbdr_pkg::MODE_READ) begin
              fired_r          <= event_r[cmd_idx];
              event_r[cmd_idx] <= 1'b0;
            end else if (mode_r == bbdr_pkg::MODE_RESTORE) begin
              raw_seen_r[cmd_idx] <= cmd_raw;
              stable_r[cmd_idx]   <= invert_r[cmd_idx] ? cmd_raw : ~cmd_raw;
              event_r[cmd_idx]    <= 1'b0;
              armed_r[cmd_idx]    <= 1'b1;
              chg_time_r[cmd_idx] <= now_r;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // rearm reference: later of fire time and change time
  always_ff @(posedge clk) begin
    if (st_r == S_MAX) begin
      ref_r <= unit_borrow ? fire_time_r[ch_r] : chg_time_r[ch_r];
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  logic [MW-1:0] smask, amask, pmask;

  always_comb begin
    smask = '0;
    amask = '0;
    pmask = '0;
    for (int i = 0; i < NCH; i++) begin
      smask[i] = stable_r[i];
      amask[i] = armed_r[i];
      pmask[i] = event_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= {{(bbdr_pkg::OUT_TDATA_W - bbdr_pkg::OUT_USED_W){1'b0}},
                     pmask, amask, smask, fired_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_one_cmd_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("command accepted while previous one in flight");

  a_ch_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(ch_r) < NCH)
    else $error("channel walk counter out of range");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(st_r == S_DONE))
    else $error("result loaded outside done state");

  a_fired_only_read: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_DONE) && fired_r |-> mode_r == bbdr_pkg::MODE_READ)
    else $error("fired set by a command other than read");

endmodule
